[rtl/ebai_pkg.sv]
package ebai_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int WORD_W          = 32;
    localparam int WORD_SH         = $clog2(WORD_W);

    localparam logic [8:0] TOTAL_RESET = 9'd256;

    // request kinds
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_NEXT  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;  // full on allocate, none on next
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] entry_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0] result_index;
        logic [1:0] status;
        logic [8:0] occupied_count;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               found;
        logic [WORD_SH-1:0] bit_idx;
    } t_find;

    // lowest set bit of a word
    function automatic t_find find_first(input logic [WORD_W-1:0] w);
        t_find f;
        f.found   = 1'b0;
        f.bit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                f.found   = 1'b1;
                f.bit_idx = WORD_SH'(i);
            end
        end
        return f;
    endfunction

endpackage

[rtl/entry_bitmap_allocator_iterator.sv]
// First-fit entry allocator with a round-robin occupancy iterator.
//
// Channels: an input beat (operation, entry_index) is taken when i_in_valid is
// high and o_in_stall is low; a result beat (result_index, status,
// occupied_count) is taken when o_out_valid is high and i_out_stall is low.
// Exactly one result beat comes back per request, in request order.
// Config: i_cfg_valid/o_cfg_ready write total_entries (9 bits); o_cfg_ready is
// always high. Write it only while no request is in flight.
//
// Timing: the occupancy bitmap sits in a single-port-per-side RAM of 32-bit
// words with a registered read. Each request is worked alone: allocate scans
// words upward from entry zero to the bound, free reads and rewrites one word,
// and next scans from the cursor round the map, one word read per cycle.
// Requests that resolve without a RAM read (full, out of range, empty, unused
// code) go straight to the done state.
// Reset clears control state and per-word valid flags, so the bitmap reads as
// all clear at once; no clearing sweep is needed. A stalled receiver holds the
// result register; the next request is still accepted and held in the engine
// until the result register frees up.
module entry_bitmap_allocator_iterator #(
    parameter int MAX_ENTRIES = ebai_pkg::MAX_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ebai_pkg::t_in_item i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ebai_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_data
);
    import ebai_pkg::*;

    localparam int DEPTH  = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = ADDR_W + WORD_SH;
    localparam int CUR_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ITER_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CUR_W > 9) ? CUR_W : 9;

    // bitmap RAM plus per-word valid flags (invalid word reads as zero)
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_wvld;
    logic [WORD_W-1:0] r_rdata;
    logic              r_rvld;

    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;

    t_state            r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [7:0]        r_idx, n_idx;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [WORD_SH-1:0] r_off, n_off;
    logic [7:0]        r_res, n_res;
    logic [1:0]        r_status, n_status;
    logic [CUR_W-1:0]  r_count, n_count;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [8:0]        r_total;
    logic              r_out_vld, n_out_vld;
    t_out_item         r_out, n_out;

    logic              in_acc;
    logic              out_free;
    logic [CUR_W-1:0]  lim;
    logic [POS_W-1:0]  start_pos;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] cand;
    t_find             hit;
    logic [POS_W-1:0]  pos;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign lim = (CMP_W'(r_total) > CMP_W'(MAX_ENTRIES)) ? CUR_W'(MAX_ENTRIES)
                                                         : CUR_W'(r_total);
    // cursor at the end of the map wraps to entry zero
    assign start_pos = (CMP_W'(r_cursor) >= CMP_W'(MAX_ENTRIES)) ? '0 : POS_W'(r_cursor);

    assign word = r_rvld ? r_rdata : '0;
    assign hit  = find_first(cand);
    assign pos  = {r_addr, hit.bit_idx};

    always_comb begin
        mask = '1;
        cand = '0;
        if (r_op == OP_ALLOC) begin
            // bits at or above the bound are off limits
            if (CUR_W'(r_addr) >= (lim >> WORD_SH)) begin
                mask = ~({WORD_W{1'b1}} << lim[WORD_SH-1:0]);
            end
            cand = ~word & mask;
        end else begin
            if (r_iter == '0) begin
                mask = {WORD_W{1'b1}} << r_off;
            end else if (r_iter == ITER_W'(DEPTH)) begin
                mask = ~({WORD_W{1'b1}} << r_off);
            end
            cand = word & mask;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_iter      = r_iter;
        n_off       = r_off;
        n_res       = r_res;
        n_status    = r_status;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_addr;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_addr;
        mem_wr_data = word;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_in.operation;
                    n_idx    = i_in.entry_index;
                    n_res    = '0;
                    n_status = STAT_OK;
                    n_iter   = '0;
                    unique case (i_in.operation)
                        OP_ALLOC: begin
                            if (lim == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_addr      = '0;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        OP_FREE: begin
                            if (CMP_W'(i_in.entry_index) < CMP_W'(lim)) begin
                                n_addr      = ADDR_W'(i_in.entry_index >> WORD_SH);
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = ADDR_W'(i_in.entry_index >> WORD_SH);
                                n_state     = S_SCAN;
                            end else begin
                                n_status = STAT_IGNORED;
                                n_state  = S_DONE;
                            end
                        end
                        OP_NEXT: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_addr      = ADDR_W'(start_pos >> WORD_SH);
                                n_off       = start_pos[WORD_SH-1:0];
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = ADDR_W'(start_pos >> WORD_SH);
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = STAT_IGNORED;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // word holds the RAM data for r_addr
                priority if (r_op == OP_ALLOC) begin
                    if (hit.found) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = word | (WORD_W'(1) << hit.bit_idx);
                        n_count     = r_count + CUR_W'(1);
                        n_res       = 8'(pos);
                        n_state     = S_DONE;
                    end else if (CUR_W'(r_addr) == ((lim - CUR_W'(1)) >> WORD_SH)) begin
                        n_status = STAT_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        n_addr      = r_addr + ADDR_W'(1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = r_addr + ADDR_W'(1);
                    end
                end else if (r_op == OP_FREE) begin
                    if (word[r_idx[WORD_SH-1:0]]) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = word & ~(WORD_W'(1) << r_idx[WORD_SH-1:0]);
                        n_count     = r_count - CUR_W'(1);
                    end else begin
                        n_status = STAT_IGNORED;
                    end
                    n_state = S_DONE;
                end else begin
                    if (hit.found) begin
                        n_cursor = CUR_W'(pos) + CUR_W'(1);
                        n_res    = 8'(pos);
                        n_state  = S_DONE;
                    end else if (r_iter == ITER_W'(DEPTH)) begin
                        n_status = STAT_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        n_addr      = (r_addr == ADDR_W'(DEPTH - 1)) ? '0
                                                                    : r_addr + ADDR_W'(1);
                        n_iter      = r_iter + ITER_W'(1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = (r_addr == ADDR_W'(DEPTH - 1)) ? '0
                                                                    : r_addr + ADDR_W'(1);
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_vld            = 1'b1;
                    n_out.result_index   = r_res;
                    n_out.status         = r_status;
                    n_out.occupied_count = 9'(r_count);
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_total   <= TOTAL_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_addr   <= n_addr;
        r_iter   <= n_iter;
        r_off    <= n_off;
        r_res    <= n_res;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // bitmap RAM
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rdata <= r_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (mem_wr_en) begin
                r_wvld[mem_wr_addr] <= 1'b1;
            end
            if (mem_rd_en) begin
                r_rvld <= r_wvld[mem_rd_addr];
            end
        end
    end

endmodule

[rtl/ebai_checker.sv]
module ebai_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ebai_pkg::t_out_item o_out
);
    import ebai_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // engine works one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // only ok results carry an index
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != STAT_OK) |-> o_out.result_index == 8'd0)
        else $error("index on a non-ok result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == STAT_OK) || (o_out.status == STAT_EMPTY) ||
                        (o_out.status == STAT_IGNORED))
        else $error("bad status code");

endmodule

bind entry_bitmap_allocator_iterator ebai_checker u_ebai_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);

[dv/entry_bitmap_allocator_iterator_tb.sv]
module entry_bitmap_allocator_iterator_tb;
    import ebai_pkg::*;

    localparam int          MAP_SIZE     = MAX_ENTRIES_DEF;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          HOLD_AT_BEAT = 700;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    // Tracks the allocator state and the results it owes, in request order.
    class occupancy_tracker;
        bit          occ_map[MAP_SIZE];
        int unsigned used;
        int unsigned scan_pos;
        logic [8:0]  total;
        t_out_item   pending_results[$];
        int          errors;

        function new();
            foreach (occ_map[i]) occ_map[i] = 1'b0;
            used     = 0;
            scan_pos = 0;
            total    = TOTAL_RESET;
            errors   = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_request(t_in_item req);
            t_out_item   exp_item;
            int unsigned lim;
            int unsigned pos;
            lim = (total > MAP_SIZE) ? MAP_SIZE : total;
            exp_item.result_index = '0;
            exp_item.status       = STAT_OK;
            case (req.operation)
                OP_ALLOC: begin
                    exp_item.status = STAT_EMPTY;
                    for (int i = 0; i < lim; i++) begin
                        if (!occ_map[i]) begin
                            occ_map[i] = 1'b1;
                            used++;
                            exp_item.result_index = i[7:0];
                            exp_item.status       = STAT_OK;
                            break;
                        end
                    end
                end
                OP_FREE: begin
                    if (req.entry_index < lim && occ_map[req.entry_index]) begin
                        occ_map[req.entry_index] = 1'b0;
                        if (used > 0) used--;
                    end else begin
                        exp_item.status = STAT_IGNORED;
                    end
                end
                OP_NEXT: begin
                    // scans the whole map, not just the configured total
                    exp_item.status = STAT_EMPTY;
                    if (used != 0) begin
                        for (int k = 0; k < MAP_SIZE; k++) begin
                            pos = ((scan_pos > MAP_SIZE) ? MAP_SIZE : scan_pos) + k;
                            if (pos >= MAP_SIZE) pos -= MAP_SIZE;
                            if (occ_map[pos]) begin
                                scan_pos              = pos + 1;
                                exp_item.result_index = pos[7:0];
                                exp_item.status       = STAT_OK;
                                break;
                            end
                        end
                    end
                end
                default: begin
                    exp_item.status = STAT_IGNORED;
                end
            endcase
            exp_item.occupied_count = used[8:0];
            pending_results = {pending_results, exp_item};
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_item;
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding");
                errors++;
                return;
            end
            exp_item = pending_results.pop_front();
            if (got.result_index !== exp_item.result_index) begin
                $error("result_index: expected %0d, got %0d",
                       exp_item.result_index, got.result_index);
                errors++;
            end
            if (got.status !== exp_item.status) begin
                $error("status: expected %0d, got %0d", exp_item.status, got.status);
                errors++;
            end
            if (got.occupied_count !== exp_item.occupied_count) begin
                $error("occupied_count: expected %0d, got %0d",
                       exp_item.occupied_count, got.occupied_count);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in        = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [8:0] i_cfg_data  = '0;

    occupancy_tracker tracker;
    int               sent_count = 0;
    bit               held_off   = 1'b0;

    entry_bitmap_allocator_iterator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Idle rates per side: sender dense / receiver busy, then swapped,
    // then a stretch with no idling at all.
    function automatic int idle_pct(input bit for_sender);
        if (sent_count < 520) return for_sender ? 7 : 58;
        if (sent_count < 1040) return for_sender ? 58 : 7;
        return 0;
    endfunction

    // Offer one request beat and hold it until taken.
    task automatic send_request(input logic [1:0] op, input logic [7:0] idx);
        while ($urandom_range(0, 99) < idle_pct(1'b1)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{operation: op, entry_index: idx};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_request(i_in);
        sent_count++;
    endtask

    // Reprogram total_entries once every owed result is back.
    task automatic write_total(input logic [8:0] value);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid   <= 1'b0;
        tracker.total = value;
    endtask

    // Random mix under one total; frees mostly target occupied entries so
    // they actually release something.
    task automatic run_phase(input logic [8:0] total, input int count, input int alloc_pct);
        int         r;
        logic [1:0] op;
        logic [7:0] idx;
        write_total(total);
        repeat (count) begin
            r   = $urandom_range(0, 99);
            idx = 8'($urandom_range(0, 255));
            if (r < 3) op = OP_UNUSED;
            else if (r < 3 + alloc_pct) op = OP_ALLOC;
            else if ($urandom_range(0, 9) < 6) op = OP_FREE;
            else op = OP_NEXT;
            if (op == OP_FREE && $urandom_range(0, 3) != 0) begin
                for (int k = 0; k < MAP_SIZE; k++) begin
                    if (tracker.occ_map[(idx + k) % MAP_SIZE]) begin
                        idx = 8'((idx + k) % MAP_SIZE);
                        break;
                    end
                end
            end
            send_request(op, idx);
        end
    endtask

    // Result side: check every taken beat, stall at random, and once hold
    // off long enough that the block backs up into its input.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) tracker.check_result(o_out);
            if (!held_off && sent_count >= HOLD_AT_BEAT) begin
                held_off    = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
            end
        end
    end

    initial begin
        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty map, first fit, frees of clear entries, iterator
        // wrap, unused opcode, then a lowered total with entries above it.
        send_request(OP_NEXT, 8'd0);     // nothing occupied
        send_request(OP_FREE, 8'd0);     // clear entry
        send_request(OP_UNUSED, 8'd255);
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_ALLOC, 8'd255);
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_FREE, 8'd1);
        send_request(OP_FREE, 8'd1);     // already clear
        send_request(OP_NEXT, 8'd0);
        send_request(OP_NEXT, 8'd0);
        send_request(OP_NEXT, 8'd0);     // wraps back to entry 0
        send_request(OP_ALLOC, 8'd0);    // refills the hole
        send_request(OP_FREE, 8'd255);
        write_total(9'd2);
        send_request(OP_FREE, 8'd2);     // occupied but above total
        send_request(OP_ALLOC, 8'd0);    // full under the lowered total
        send_request(OP_NEXT, 8'd0);
        send_request(OP_NEXT, 8'd0);     // still reports entry above total
        send_request(OP_ALLOC, 8'd0);
        send_request(OP_FREE, 8'd0);
        send_request(OP_ALLOC, 8'd0);

        run_phase(9'd8,   120, 50);
        run_phase(9'd0,   40,  50);   // allocate full, free ignored
        run_phase(9'd256, 420, 80);   // fills the whole map
        run_phase(9'd40,  200, 40);   // lowered total, many entries above it
        run_phase(9'd511, 250, 45);   // total beyond map size
        run_phase(9'd1,   80,  50);
        run_phase(9'd300, 300, 35);
        run_phase(9'd170, 140, 50);

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
